// ----- sv/iqdg_pkg.sv -----
`timescale 1ns / 1ps
package iqdg_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_WIDTH   = 8;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int DONE_W  = $clog2(MAX_WIDTH + 1);
	localparam int DW_W    = 4;
	localparam int LIM_W   = (DONE_W > DW_W) ? DONE_W : DW_W;
	localparam int QSIZE_W = 7;
	localparam int FREE_W  = (OCC_W > QSIZE_W) ? OCC_W : QSIZE_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [QSIZE_W-1:0] QUEUE_SIZE_RST     = QSIZE_W'(32);
	localparam logic [DW_W-1:0]    DISPATCH_WIDTH_RST = DW_W'(4);

	typedef enum logic [1:0] {
		CMD_ENQUEUE  = 2'd0,
		CMD_SQUASH   = 2'd1,
		CMD_DISPATCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_UOP    = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_SQUASH = 2'd2
	} kind_t;

	typedef enum logic {
		REG_QUEUE_SIZE     = 1'b0,
		REG_DISPATCH_WIDTH = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVAL,
		ST_SQUASH,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic [1:0]  num_cc_writes;
		logic [2:0]  num_writes;
		logic [2:0]  num_reads;
		logic        halt_dispatch;
		logic [31:0] insn_tag;
	} uop_rec_t;

	localparam int UOP_W = $bits(uop_rec_t);

	typedef struct packed {
		logic [QSIZE_W-1:0] queue_size;
		logic [DW_W-1:0]    dispatch_width;
	} cfg_t;

endpackage

// ----- sv/iqdg_if.sv -----
`timescale 1ns / 1ps
interface iqdg_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] insn_tag;
	logic        halt_dispatch;
	logic [2:0]  num_reads;
	logic [2:0]  num_writes;
	logic [1:0]  num_cc_writes;
	logic [3:0]  squash_cause;
	logic [6:0]  dispatch_slots;
	logic        core_synced;
	logic [9:0]  free_int_regs;
	logic [9:0]  free_fp_regs;
	logic [9:0]  free_cc_regs;

	modport source (
		output valid, command, insn_tag, halt_dispatch, num_reads, num_writes,
		       num_cc_writes, squash_cause, dispatch_slots, core_synced,
		       free_int_regs, free_fp_regs, free_cc_regs,
		input  ready
	);
	modport sink (
		input  valid, command, insn_tag, halt_dispatch, num_reads, num_writes,
		       num_cc_writes, squash_cause, dispatch_slots, core_synced,
		       free_int_regs, free_fp_regs, free_cc_regs,
		output ready
	);
endinterface

interface iqdg_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] out_tag;
	logic [3:0]  out_cause;
	logic [6:0]  queue_free;
	logic [6:0]  queue_count;
	logic        stalled;
	logic        dropped;
	logic        last;

	modport source (
		output valid, kind, out_tag, out_cause, queue_free, queue_count,
		       stalled, dropped, last,
		input  ready
	);
	modport sink (
		input  valid, kind, out_tag, out_cause, queue_free, queue_count,
		       stalled, dropped, last,
		output ready
	);
endinterface

// ----- sv/iqdg_ram.sv -----
`timescale 1ns / 1ps
module iqdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/iqdg_cfg.sv -----
`timescale 1ns / 1ps
module iqdg_cfg
	import iqdg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	// word-aligned registers: bit 2 picks the register
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queue_size     <= QUEUE_SIZE_RST;
			cfg_q.dispatch_width <= DISPATCH_WIDTH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_QUEUE_SIZE:     cfg_q.queue_size     <= pwdata[QSIZE_W-1:0];
				REG_DISPATCH_WIDTH: cfg_q.dispatch_width <= pwdata[DW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_QUEUE_SIZE:     prdata = PDATA_W'(cfg_q.queue_size);
			REG_DISPATCH_WIDTH: prdata = PDATA_W'(cfg_q.dispatch_width);
		endcase
	end

endmodule

// ----- sv/instruction_queue_dispatch_gate_unit.sv -----
`timescale 1ns / 1ps
// Order: an enqueue or unused command goes through the status state, which loads its status word;
//   a squash goes through the squash state, which loads its forwarded-squash word, then the status state.
// Dispatch: a check state and an evaluate state per issued uop (uop-store read, then issue), until a
//   check fails or an evaluate is blocked, then the status word.
// Flow: one command word at a time; the next is taken in the cycle after the status word is
//   loaded; receiver stalls hold any state that loads a result word.
// Reset: queue empty, sync flag clear, queue_size 32, dispatch_width 4; uop store not cleared.
module instruction_queue_dispatch_gate_unit
	import iqdg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	iqdg_cmd_if.sink           cmd_ch,
	iqdg_res_if.source         res_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration registers
	cfg_t cfg;

	iqdg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// queue control state
	state_t             state_q, state_d;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic               sync_pending_q;
	logic               drop_q;

	// latched command word
	logic [3:0]         cause_q;
	logic               synced_q;
	logic [9:0]         fp_q;
	logic [6:0]         slots_in_q;
	logic [9:0]         int_in_q;
	logic [9:0]         cc_in_q;

	// per-dispatch budgets
	logic [6:0]         slots_q;
	logic [9:0]         xregs_q;
	logic [9:0]         ccs_q;
	logic [DONE_W-1:0]  done_q;

	// result register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [31:0]        tag_q;
	logic [3:0]         ocause_q;
	logic [6:0]         qfree_q;
	logic [6:0]         qcount_q;
	logic               stalled_q;
	logic               dropped_q;
	logic               last_q;

	logic               accept;
	logic               full;
	logic               enq_we;
	uop_rec_t           wr_rec;
	uop_rec_t           rd_rec;
	logic [UOP_W-1:0]   rd_data;

	assign accept = cmd_ch.valid && cmd_ch.ready;
	assign full   = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign enq_we = accept && (cmd_t'(cmd_ch.command) == CMD_ENQUEUE) && !full;

	assign wr_rec.insn_tag      = cmd_ch.insn_tag;
	assign wr_rec.halt_dispatch = cmd_ch.halt_dispatch;
	assign wr_rec.num_reads     = cmd_ch.num_reads;
	assign wr_rec.num_writes    = cmd_ch.num_writes;
	assign wr_rec.num_cc_writes = cmd_ch.num_cc_writes;

	// Uop store: written at the tail on an enqueue, read at the head every cycle.
	// Enqueue and dispatch never overlap, so no forwarding path is needed: the
	// check cycle reads the head and the evaluate cycle sees its data.
	iqdg_ram #(
		.WIDTH (UOP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (enq_we),
		.waddr (tail_q),
		.wdata (wr_rec),
		.raddr (head_q),
		.rdata (rd_data)
	);

	assign rd_rec = uop_rec_t'(rd_data);

	// Pointer wrap for any depth
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Width limit: clamp to MAX_WIDTH
	logic [LIM_W-1:0] width_lim;
	assign width_lim = (LIM_W'(cfg.dispatch_width) > LIM_W'(MAX_WIDTH)) ?
		LIM_W'(MAX_WIDTH) : LIM_W'(cfg.dispatch_width);

	// Loop guard, evaluated in the check cycle
	logic go_on;
	assign go_on = (slots_q != '0) && (LIM_W'(done_q) < width_lim) && (occ_q != '0) &&
		!sync_pending_q && (xregs_q != '0) && (fp_q != '0) && (ccs_q != '0);

	// Head uop test, evaluated once its data is back
	logic [3:0]  int_cost;
	logic        halt_block;
	logic        blocked;
	assign int_cost   = {1'b0, rd_rec.num_reads} + {1'b0, rd_rec.num_writes};
	assign halt_block = rd_rec.halt_dispatch && !(synced_q && (done_q == '0));
	assign blocked    = halt_block || ({6'b0, int_cost} > xregs_q) ||
		({8'b0, rd_rec.num_cc_writes} > ccs_q);

	// Result register may be loaded when empty or being drained
	logic out_free;
	assign out_free = !out_valid_q || res_ch.ready;

	// Status fields from post-item state and this word's downstream view
	logic [FREE_W-1:0] qfree_w;
	logic              stall_w;
	assign qfree_w = (FREE_W'(cfg.queue_size) > FREE_W'(occ_q)) ?
		FREE_W'(cfg.queue_size) - FREE_W'(occ_q) : '0;
	assign stall_w = (occ_q == '0) || (slots_in_q == '0) || (sync_pending_q && !synced_q) ||
		(int_in_q == '0) || (fp_q == '0) || (cc_in_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_ch.command)
						CMD_SQUASH:   state_d = ST_SQUASH;
						CMD_DISPATCH: state_d = ST_CHECK;
						default:      state_d = ST_STATUS;
					endcase
				end
			end
			ST_CHECK:  state_d = go_on ? ST_EVAL : ST_STATUS;
			ST_EVAL: begin
				if (blocked) begin
					state_d = ST_STATUS;
				end else if (out_free) begin
					state_d = ST_CHECK;
				end
			end
			ST_SQUASH: state_d = out_free ? ST_STATUS : ST_SQUASH;
			ST_STATUS: state_d = out_free ? ST_IDLE : ST_STATUS;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	logic issue, emit_squash, emit_status;
	always_comb begin
		cmd_ch.ready = 1'b0;
		issue        = 1'b0;
		emit_squash  = 1'b0;
		emit_status  = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd_ch.ready = 1'b1;
			ST_EVAL:   issue        = !blocked && out_free;
			ST_SQUASH: emit_squash  = out_free;
			ST_STATUS: emit_status  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Queue pointers, occupancy and sync flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			tail_q         <= '0;
			occ_q          <= '0;
			sync_pending_q <= 1'b0;
			drop_q         <= 1'b0;
		end else if (accept) begin
			drop_q <= (cmd_t'(cmd_ch.command) == CMD_ENQUEUE) && full;
			unique case (cmd_ch.command)
				CMD_ENQUEUE: begin
					if (!full) begin
						tail_q <= ptr_inc(tail_q);
						occ_q  <= occ_q + 1'b1;
					end
				end
				CMD_SQUASH: begin
					// empty the queue; the flag survives a squash
					head_q <= '0;
					tail_q <= '0;
					occ_q  <= '0;
				end
				CMD_DISPATCH: begin
					if (cmd_ch.core_synced) begin
						sync_pending_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end else if (issue) begin
			head_q <= ptr_inc(head_q);
			occ_q  <= occ_q - 1'b1;
			if (rd_rec.halt_dispatch) begin
				sync_pending_q <= 1'b1;
			end
		end
	end

	// Latch the command word and per-dispatch budgets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (accept) begin
			done_q <= '0;
		end else if (issue) begin
			done_q <= done_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cause_q    <= cmd_ch.squash_cause;
			synced_q   <= cmd_ch.core_synced;
			fp_q       <= cmd_ch.free_fp_regs;
			slots_in_q <= cmd_ch.dispatch_slots;
			int_in_q   <= cmd_ch.free_int_regs;
			cc_in_q    <= cmd_ch.free_cc_regs;
			slots_q    <= cmd_ch.dispatch_slots;
			xregs_q    <= cmd_ch.free_int_regs;
			ccs_q      <= cmd_ch.free_cc_regs;
		end else if (issue) begin
			slots_q <= slots_q - 1'b1;
			xregs_q <= xregs_q - {6'b0, int_cost};
			ccs_q   <= ccs_q - {8'b0, rd_rec.num_cc_writes};
		end
	end

	// Result register: hold until taken, load when a word is ready
	logic load_out;
	assign load_out = issue || emit_squash || emit_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Fields that do not belong to a word's kind are driven to zero
	always_ff @(posedge clk) begin
		if (load_out) begin
			priority if (issue) begin
				kind_q    <= KIND_UOP;
				tag_q     <= rd_rec.insn_tag;
				ocause_q  <= '0;
				qfree_q   <= '0;
				qcount_q  <= '0;
				stalled_q <= 1'b0;
				dropped_q <= 1'b0;
				last_q    <= 1'b0;
			end else if (emit_squash) begin
				kind_q    <= KIND_SQUASH;
				tag_q     <= '0;
				ocause_q  <= cause_q;
				qfree_q   <= '0;
				qcount_q  <= '0;
				stalled_q <= 1'b0;
				dropped_q <= 1'b0;
				last_q    <= 1'b0;
			end else begin
				kind_q    <= KIND_STATUS;
				tag_q     <= '0;
				ocause_q  <= '0;
				qfree_q   <= qfree_w[6:0];
				qcount_q  <= 7'(occ_q);
				stalled_q <= stall_w;
				dropped_q <= drop_q;
				last_q    <= 1'b1;
			end
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.kind        = kind_q;
	assign res_ch.out_tag     = tag_q;
	assign res_ch.out_cause   = ocause_q;
	assign res_ch.queue_free  = qfree_q;
	assign res_ch.queue_count = qcount_q;
	assign res_ch.stalled     = stalled_q;
	assign res_ch.dropped     = dropped_q;
	assign res_ch.last        = last_q;

	// Occupancy never passes the storage depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy beyond storage depth");

	// A squash leaves the queue empty
	a_squash_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && cmd_ch.ready && (cmd_ch.command == CMD_SQUASH)) |=> (occ_q == '0))
		else $error("queue not empty after squash");

	// Only the status word closes an item
	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.last) |-> (res_ch.kind == KIND_STATUS))
		else $error("last set on a non-status word");

	// After a status word is loaded, the block is ready for the next command
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_status |=> cmd_ch.ready)
		else $error("not ready after status word");

	// A uop is issued only within the width limit
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (LIM_W'(done_q) < width_lim))
		else $error("dispatch beyond width limit");

endmodule

// ----- dv/instruction_queue_dispatch_gate_unit_test.sv -----
`timescale 1ns / 1ps
module instruction_queue_dispatch_gate_unit_test;
	import iqdg_pkg::*;

	// Command 3 has no meaning: the block only answers with a status word
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int LONG_HOLD      = 300;   // receiver hold-off under pressure
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
	localparam int TAIL_CYCLES    = 30;    // quiet tail after the last owed word is back

	// One command word as the sender offers it
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] insn_tag;
		logic        halt_dispatch;
		logic [2:0]  num_reads;
		logic [2:0]  num_writes;
		logic [1:0]  num_cc_writes;
		logic [3:0]  squash_cause;
		logic [6:0]  dispatch_slots;
		logic        core_synced;
		logic [9:0]  free_int_regs;
		logic [9:0]  free_fp_regs;
		logic [9:0]  free_cc_regs;
	} cmd_word_t;

	// One result word as the block returns it
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_tag;
		logic [3:0]  out_cause;
		logic [6:0]  queue_free;
		logic [6:0]  queue_count;
		logic        stalled;
		logic        dropped;
		logic        last;
	} res_word_t;

	// Shadow of the uop queue and dispatch gate, plus the words still owed
	class dispatch_scoreboard;
		uop_rec_t    uop_mem[QUEUE_DEPTH];
		int unsigned head_ptr;
		int unsigned tail_ptr;
		int unsigned held;
		bit          sync_wait;
		int unsigned cfg_qsize;
		int unsigned cfg_width;
		res_word_t   due[$];
		int unsigned mismatches;

		function new();
			head_ptr   = 0;
			tail_ptr   = 0;
			held       = 0;
			sync_wait  = 1'b0;
			cfg_qsize  = QUEUE_SIZE_RST;
			cfg_width  = DISPATCH_WIDTH_RST;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			if (idx == REG_QUEUE_SIZE)
				cfg_qsize = value & 32'd127;
			else
				cfg_width = value & 32'd15;
		endfunction

		// Append one owed word at the end of the list
		function void owe(res_word_t r);
			due.insert(due.size(), r);
		endfunction

		// Advance the shadow by one accepted command and queue the words it owes
		function void take_command(cmd_word_t w);
			res_word_t r;
			uop_rec_t  u;
			bit        refused;
			int        slots_left;
			int        int_left;
			int        cc_left;
			int        width;
			int        issued;
			refused = 1'b0;
			case (w.command)
				CMD_ENQUEUE: begin
					// storage full: drop the uop, queue_size plays no part here
					if (held >= QUEUE_DEPTH) begin
						refused = 1'b1;
					end else begin
						u.insn_tag        = w.insn_tag;
						u.halt_dispatch   = w.halt_dispatch;
						u.num_reads       = w.num_reads;
						u.num_writes      = w.num_writes;
						u.num_cc_writes   = w.num_cc_writes;
						uop_mem[tail_ptr] = u;
						tail_ptr          = (tail_ptr + 1) % QUEUE_DEPTH;
						held++;
					end
				end
				CMD_SQUASH: begin
					head_ptr    = 0;
					tail_ptr    = 0;
					held        = 0;
					r           = '0;
					r.kind      = KIND_SQUASH;
					r.out_cause = w.squash_cause;
					owe(r);
				end
				CMD_DISPATCH: begin
					if (w.core_synced)
						sync_wait = 1'b0;
					slots_left = w.dispatch_slots;
					int_left   = w.free_int_regs;
					cc_left    = w.free_cc_regs;
					width      = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
					issued     = 0;
					while (slots_left > 0 && issued < width && held > 0 && !sync_wait &&
					       int_left > 0 && w.free_fp_regs != 0 && cc_left > 0) begin
						u = uop_mem[head_ptr];
						// a halting uop only leads a synchronised cycle
						if (u.halt_dispatch && !(w.core_synced && issued == 0))
							break;
						int_left -= int'(u.num_reads) + int'(u.num_writes);
						cc_left  -= int'(u.num_cc_writes);
						if (int_left < 0 || cc_left < 0)
							break;
						head_ptr  = (head_ptr + 1) % QUEUE_DEPTH;
						held--;
						r         = '0;
						r.kind    = KIND_UOP;
						r.out_tag = u.insn_tag;
						owe(r);
						if (u.halt_dispatch)
							sync_wait = 1'b1;
						issued++;
						slots_left--;
					end
				end
				default: ;
			endcase
			r             = '0;
			r.kind        = KIND_STATUS;
			r.queue_free  = (cfg_qsize > held) ? 7'(cfg_qsize - held) : 7'd0;
			r.queue_count = 7'(held);
			r.stalled     = held == 0 || w.dispatch_slots == 0 ||
			                (sync_wait && !w.core_synced) || w.free_int_regs == 0 ||
			                w.free_fp_regs == 0 || w.free_cc_regs == 0;
			r.dropped     = refused;
			r.last        = 1'b1;
			owe(r);
		endfunction

		function void match_word(res_word_t got);
			res_word_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with nothing due: kind %0d tag %h",
					         got.kind, got.out_tag);
				return;
			end
			want = due[0];
			due.delete(0);
			if (got.kind !== want.kind || got.out_tag !== want.out_tag ||
			    got.out_cause !== want.out_cause || got.queue_free !== want.queue_free ||
			    got.queue_count !== want.queue_count || got.stalled !== want.stalled ||
			    got.dropped !== want.dropped || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch, expected: kind %0d tag %h cause %0d free %0d",
					         want.kind, want.out_tag, want.out_cause, want.queue_free,
					         " count %0d stall %b drop %b last %b",
					         want.queue_count, want.stalled, want.dropped, want.last);
					$display("                   actual: kind %0d tag %h cause %0d free %0d",
					         got.kind, got.out_tag, got.out_cause, got.queue_free,
					         " count %0d stall %b drop %b last %b",
					         got.queue_count, got.stalled, got.dropped, got.last);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic              pready;

	iqdg_cmd_if cmd_if ();
	iqdg_res_if res_if ();

	instruction_queue_dispatch_gate_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_if),
		.res_ch  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	dispatch_scoreboard sb = new();

	bit          no_idle      = 1'b0;  // both sides run without gaps
	bit          hold_off_req = 1'b0;  // ask the receiver for one long hold-off
	logic        sink_ready   = 1'b0;
	int          sink_gap     = 0;
	int unsigned idle_cycles  = 0;

	assign res_if.ready = sink_ready;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long
	function automatic int idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Free register count: a few zero, some scarce, most plentiful
	function automatic logic [9:0] reg_pool();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 6)
			return 10'd0;
		if (p < 26)
			return 10'($urandom_range(1, 15));
		return 10'($urandom_range(16, 1023));
	endfunction

	function automatic cmd_word_t rand_word(logic [1:0] cmd);
		cmd_word_t w;
		w.command        = cmd;
		w.insn_tag       = $urandom;
		w.halt_dispatch  = ($urandom_range(0, 5) == 0);
		w.num_reads      = 3'($urandom_range(0, 7));
		w.num_writes     = 3'($urandom_range(0, 7));
		w.num_cc_writes  = 2'($urandom_range(0, 3));
		w.squash_cause   = 4'($urandom_range(0, 15));
		w.dispatch_slots = ($urandom_range(0, 99) < 8) ? 7'd0 : 7'($urandom_range(1, 64));
		w.core_synced    = ($urandom_range(0, 3) != 0);
		w.free_int_regs  = reg_pool();
		w.free_fp_regs   = reg_pool();
		w.free_cc_regs   = reg_pool();
		return w;
	endfunction

	// Downstream wide open: every slot free, core synchronised, all registers free
	function automatic cmd_word_t calm_word(logic [1:0] cmd);
		cmd_word_t w;
		w                = '0;
		w.command        = cmd;
		w.dispatch_slots = 7'd64;
		w.core_synced    = 1'b1;
		w.free_int_regs  = 10'd1023;
		w.free_fp_regs   = 10'd1023;
		w.free_cc_regs   = 10'd1023;
		return w;
	endfunction

	task automatic put_payload(input cmd_word_t w);
		cmd_if.command       <= w.command;
		cmd_if.insn_tag      <= w.insn_tag;
		cmd_if.halt_dispatch <= w.halt_dispatch;
		cmd_if.num_reads     <= w.num_reads;
		cmd_if.num_writes    <= w.num_writes;
		cmd_if.num_cc_writes <= w.num_cc_writes;
		cmd_if.squash_cause  <= w.squash_cause;
		cmd_if.dispatch_slots <= w.dispatch_slots;
		cmd_if.core_synced   <= w.core_synced;
		cmd_if.free_int_regs <= w.free_int_regs;
		cmd_if.free_fp_regs  <= w.free_fp_regs;
		cmd_if.free_cc_regs  <= w.free_cc_regs;
	endtask

	// Offer one command word; valid stays high into the next word when no gap falls
	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		put_payload(w);
		cmd_if.valid <= 1'b1;
		do @(posedge clk); while (!cmd_if.ready);
		sb.take_command(w);
	endtask

	// Hold the sender until every owed word is back, then let the block settle
	task automatic wait_drain();
		cmd_if.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup then access; psel is left high so a second write can follow at once
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
	endtask

	task automatic set_config(input int unsigned qsize, input int unsigned width);
		apb_write(REG_QUEUE_SIZE, qsize);
		apb_write(REG_DISPATCH_WIDTH, width);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly bursts of enqueues followed by dispatches, with squashes and noise mixed in
	task automatic random_run(input int unsigned n);
		int unsigned sent;
		int unsigned p;
		int unsigned k;
		sent = 0;
		while (sent < n) begin
			p = $urandom_range(0, 99);
			if (p < 70) begin
				k = $urandom_range(1, 6);
				repeat (k) send_word(rand_word(CMD_ENQUEUE));
				sent += k;
				k = $urandom_range(1, 3);
				repeat (k) send_word(rand_word(CMD_DISPATCH));
				sent += k;
			end else if (p < 86) begin
				send_word(rand_word(CMD_DISPATCH));
				sent++;
			end else if (p < 94) begin
				send_word(rand_word(CMD_SQUASH));
				sent++;
			end else begin
				// answered with a status word only: not counted
				send_word(rand_word(CMD_UNUSED));
			end
		end
	endtask

	// Receiver: check each accepted word, then pick the gap before the next one
	always @(posedge clk) begin : sink_side
		res_word_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.kind        = res_if.kind;
			got.out_tag     = res_if.out_tag;
			got.out_cause   = res_if.out_cause;
			got.queue_free  = res_if.queue_free;
			got.queue_count = res_if.queue_count;
			got.stalled     = res_if.stalled;
			got.dropped     = res_if.dropped;
			got.last        = res_if.last;
			sb.match_word(got);
			sink_gap = idle_len();
		end
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			sink_gap     = LONG_HOLD;
		end
		if (sink_gap > 0) begin
			sink_ready <= 1'b0;
			sink_gap--;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		cmd_word_t w;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		cmd_if.valid <= 1'b0;
		put_payload('0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset configuration (queue_size 32, width 4) ----
		// dispatch on an empty queue: status only, stalled
		send_word(calm_word(CMD_DISPATCH));
		// field extremes on enqueue
		send_word(calm_word(CMD_ENQUEUE));
		w               = calm_word(CMD_ENQUEUE);
		w.insn_tag      = 32'hFFFF_FFFF;
		w.num_reads     = 3'd7;
		w.num_writes    = 3'd7;
		w.num_cc_writes = 2'd3;
		send_word(w);
		w               = calm_word(CMD_ENQUEUE);
		w.insn_tag      = 32'h5A5A_0001;
		w.halt_dispatch = 1'b1;
		send_word(w);
		w           = calm_word(CMD_ENQUEUE);
		w.insn_tag  = 32'h1234_5678;
		w.num_reads = 3'd1;
		send_word(w);
		// unsynced: the first two go, the halting uop blocks
		w             = calm_word(CMD_DISPATCH);
		w.core_synced = 1'b0;
		send_word(w);
		send_word(w);
		// synchronised: the halting uop goes alone and raises the sync flag
		send_word(calm_word(CMD_DISPATCH));
		// sync pending while unsynced: stalled
		send_word(w);
		// register shortfall on the int count
		w            = calm_word(CMD_ENQUEUE);
		w.insn_tag   = 32'hC0DE_0010;
		w.num_reads  = 3'd7;
		w.num_writes = 3'd7;
		send_word(w);
		w               = calm_word(CMD_DISPATCH);
		w.free_int_regs = 10'd10;
		send_word(w);
		// register shortfall on the cc count
		w               = calm_word(CMD_ENQUEUE);
		w.insn_tag      = 32'hC0DE_0012;
		w.num_cc_writes = 2'd3;
		send_word(w);
		w              = calm_word(CMD_DISPATCH);
		w.free_cc_regs = 10'd2;
		send_word(w);
		// each zero-count stall reason with the queue non-empty
		w                = calm_word(CMD_DISPATCH);
		w.dispatch_slots = 7'd0;
		send_word(w);
		w              = calm_word(CMD_DISPATCH);
		w.free_fp_regs = 10'd0;
		send_word(w);
		w              = calm_word(CMD_DISPATCH);
		w.free_cc_regs = 10'd0;
		send_word(w);
		w               = calm_word(CMD_DISPATCH);
		w.free_int_regs = 10'd0;
		send_word(w);
		// unused command: status only
		send_word(calm_word(CMD_UNUSED));
		w              = calm_word(CMD_SQUASH);
		w.squash_cause = 4'd15;
		send_word(w);
		send_word(calm_word(CMD_SQUASH));
		// halting uop with every field at its top, one slot downstream
		w               = calm_word(CMD_ENQUEUE);
		w.insn_tag      = 32'hFFFF_FFFF;
		w.halt_dispatch = 1'b1;
		w.num_reads     = 3'd7;
		w.num_writes    = 3'd7;
		w.num_cc_writes = 2'd3;
		send_word(w);
		w                = calm_word(CMD_DISPATCH);
		w.dispatch_slots = 7'd1;
		send_word(w);
		random_run(8);

		// ---- width 0 dispatches nothing; fill storage until enqueues drop ----
		wait_drain();
		set_config(0, 0);
		send_word(rand_word(CMD_SQUASH));
		repeat (QUEUE_DEPTH + 2) send_word(rand_word(CMD_ENQUEUE));
		repeat (2) send_word(calm_word(CMD_DISPATCH));
		random_run(4);

		// ---- full width on a full queue; first stretch without gaps ----
		wait_drain();
		set_config(64, MAX_WIDTH);
		no_idle = 1'b1;
		repeat (2) send_word(calm_word(CMD_DISPATCH));
		random_run(6);
		no_idle = 1'b0;
		random_run(6);

		// ---- register tops: width above MAX_WIDTH acts as MAX_WIDTH ----
		wait_drain();
		set_config(127, 15);
		send_word(calm_word(CMD_DISPATCH));
		random_run(6);

		// ---- narrow settings, receiver hold-off and a full drain mid-phase ----
		wait_drain();
		set_config(1, 1);
		random_run(4);
		hold_off_req = 1'b1;
		no_idle      = 1'b1;
		repeat (10) send_word(rand_word(CMD_ENQUEUE));
		no_idle = 1'b0;
		wait_drain();
		random_run(4);

		// ---- random settings ----
		repeat (2) begin
			wait_drain();
			set_config($urandom_range(0, 127), $urandom_range(0, 15));
			random_run(6);
		end

		cmd_if.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
